// ===== sv/sbda_pkg.sv =====
// Shared constants and types for the signed binary to decimal ASCII unit.
// No dependencies; every other file imports this package.
package sbda_pkg;

	// width of the input field and the number of its low bits taken as two's complement
	localparam int VALUE_BITS  = 64;
	localparam int VALUE_WIDTH = 64;

	// decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1)
	localparam int NUM_DIGITS  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
	localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS + 1);
	localparam int DIGIT_SEL_W = $clog2(NUM_DIGITS);

	// double-dabble: magnitude bits consumed per clock
	localparam int BITS_PER_STEP = 4;
	localparam int STEPS         = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int STEP_W        = $clog2(STEPS);
	localparam int PAD_W         = STEPS * BITS_PER_STEP;

	// request queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int CHAR_W = 7;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

	typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

	typedef struct packed {
		logic                   negative;
		logic [DIGIT_CNT_W-1:0] num_digits;
		bcd_t                   digits;
	} entry_t;

endpackage

// ===== sv/sbda_in_if.sv =====
// Input channel: one signed integer per request, valid/ready handshake.
// Depends on sbda_pkg.
interface sbda_in_if;
	import sbda_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

// ===== sv/sbda_out_if.sv =====
// Output channel: one ASCII character per request, last one of a number marked.
// Depends on sbda_pkg.
interface sbda_out_if;
	import sbda_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== sv/sbda_front.sv =====
// Front end: takes a number, forms sign and magnitude, converts to BCD by
// double-dabble a few bits per clock, and pushes the result to the queue. Uses sbda_pkg.
module sbda_front (
	input  logic            clk,
	input  logic            arst_n,
	sbda_in_if.sink         number,
	output logic            push_valid,
	input  logic            push_ready,
	output sbda_pkg::entry_t push_entry
);
	import sbda_pkg::*;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_CONV = 3'b010,
		F_PUSH = 3'b100
	} front_state_t;

	front_state_t            state_q;
	logic [STEP_W-1:0]       step_q;
	logic                    neg_q;
	logic [PAD_W-1:0]        mag_q;
	bcd_t                    bcd_q;

	logic [VALUE_WIDTH-1:0]  raw;
	logic [VALUE_WIDTH-1:0]  mag_in;
	bcd_t                    bcd_nx;
	logic [PAD_W-1:0]        mag_nx;

	// add 3 to every digit of 5 or more, then shift one magnitude bit in
	function automatic bcd_t dabble_bit(bcd_t bcd_in, logic shift_in);
		bcd_t                    adj;
		logic [NUM_DIGITS*4-1:0] flat;
		adj = bcd_in;
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (adj[d] >= 4'd5)
				adj[d] = adj[d] + 4'd3;
		end
		flat = adj;
		return {flat[NUM_DIGITS*4-2:0], shift_in};
	endfunction

	function automatic logic [DIGIT_CNT_W-1:0] count_digits(bcd_t bcd_in);
		logic [DIGIT_CNT_W-1:0] n;
		n = DIGIT_CNT_W'(1);
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_in[i] != 4'd0)
				n = DIGIT_CNT_W'(i + 1);
		end
		return n;
	endfunction

	assign raw    = number.value[VALUE_WIDTH-1:0];
	// most negative value wraps to its true magnitude in VALUE_WIDTH bits
	assign mag_in = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

	always_comb begin
		bcd_nx = bcd_q;
		mag_nx = mag_q;
		for (int b = 0; b < BITS_PER_STEP; b++) begin
			bcd_nx = dabble_bit(bcd_nx, mag_nx[PAD_W-1]);
			mag_nx = {mag_nx[PAD_W-2:0], 1'b0};
		end
	end

	assign number.ready = (state_q == F_IDLE);
	assign push_valid   = (state_q == F_PUSH);

	always_comb begin
		push_entry.negative   = neg_q;
		push_entry.num_digits = count_digits(bcd_q);
		push_entry.digits     = bcd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (number.valid) begin
						state_q <= F_CONV;
						step_q  <= STEP_W'(STEPS - 1);
					end
				end
				F_CONV: begin
					if (step_q == '0)
						state_q <= F_PUSH;
					else
						step_q <= step_q - 1'b1;
				end
				F_PUSH: begin
					if (push_ready)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && number.valid) begin
			neg_q <= raw[VALUE_WIDTH-1];
			mag_q <= PAD_W'(mag_in);
			bcd_q <= '0;
		end else if (state_q == F_CONV) begin
			mag_q <= mag_nx;
			bcd_q <= bcd_nx;
		end
	end

endmodule

// ===== sv/sbda_fifo.sv =====
// Short request queue between the converter front and the character back end.
// Uses sbda_pkg for depth and entry type.
module sbda_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  sbda_pkg::entry_t wr_entry,
	output logic             rd_valid,
	input  logic             rd_ready,
	output sbda_pkg::entry_t rd_entry
);
	import sbda_pkg::*;

	entry_t              entries_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_wr;
	logic                do_rd;

	assign wr_ready = (count_q != QCNT_W'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_entry = entries_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			entries_q[wr_ptr_q] <= wr_entry;
	end

endmodule

// ===== sv/sbda_back.sv =====
// Back end: pops a converted number and sends its text, sign first, then the
// digits most significant first, through a registered output. Uses sbda_pkg.
module sbda_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  sbda_pkg::entry_t pop_entry,
	sbda_out_if.source       text
);
	import sbda_pkg::*;

	logic                   busy_q;
	logic                   neg_q;
	logic [DIGIT_CNT_W-1:0] left_q;
	bcd_t                   digits_q;
	logic                   out_valid_q;
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;

	logic                   out_free;
	logic                   do_pop;
	logic                   emit;
	logic [DIGIT_CNT_W-1:0] sel;
	logic [3:0]             digit;

	assign out_free  = !out_valid_q || text.ready;
	assign pop_ready = !busy_q;
	assign do_pop    = pop_valid && !busy_q;
	assign emit      = busy_q && out_free;

	// left_q counts digits still to send; the next one sits at left_q-1
	assign sel   = left_q - 1'b1;
	assign digit = digits_q[sel[DIGIT_SEL_W-1:0]];

	assign text.valid     = out_valid_q;
	assign text.char_code = char_q;
	assign text.last_char = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			neg_q       <= 1'b0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free)
				out_valid_q <= busy_q;
			if (do_pop) begin
				busy_q <= 1'b1;
				neg_q  <= pop_entry.negative;
				left_q <= pop_entry.num_digits;
			end else if (emit) begin
				if (neg_q) begin
					neg_q <= 1'b0;
				end else begin
					left_q <= sel;
					if (left_q == DIGIT_CNT_W'(1))
						busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop)
			digits_q <= pop_entry.digits;
		if (emit) begin
			if (neg_q) begin
				char_q <= CHAR_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= CHAR_ZERO + CHAR_W'(digit);
				last_q <= (left_q == DIGIT_CNT_W'(1));
			end
		end
	end

endmodule

// ===== sv/signed_binary_to_decimal_ascii_unit.sv =====
// Signed binary to decimal ASCII unit: top level joining front, queue and back.
// Depends on sbda_pkg, sbda_in_if, sbda_out_if, sbda_front, sbda_fifo, sbda_back.
//
// Each request on number carries a signed integer (low VALUE_WIDTH bits used);
// text returns its decimal characters, a minus sign first when negative, the
// last digit flagged by last_char. Zero gives one '0'; the most negative value
// comes out with its full magnitude. The front accepts a number, runs 16
// double-dabble steps of 4 bits and hands the result to the queue; the back
// loads a number only once the last one is sent, then sends one character a
// cycle while text is ready. The longest text is a minus sign and 19 digits.
// With the two-entry queue between them, the two sides stall independently.
module signed_binary_to_decimal_ascii_unit (
	input  logic       clk,
	input  logic       arst_n,
	sbda_in_if.sink    number,
	sbda_out_if.source text
);
	import sbda_pkg::*;

	logic   push_valid;
	logic   push_ready;
	entry_t push_entry;
	logic   pop_valid;
	logic   pop_ready;
	entry_t pop_entry;
	logic   start_q;

	sbda_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.number     (number),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	sbda_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_entry (push_entry),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_entry (pop_entry)
	);

	sbda_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.text      (text)
	);

	// high when the next character is a number's minus sign or its first digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			start_q <= 1'b1;
		else if (text.valid && text.ready)
			start_q <= text.last_char || (text.char_code == CHAR_MINUS);
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		text.valid |-> (text.char_code == CHAR_MINUS) ||
			((text.char_code >= CHAR_ZERO) && (text.char_code <= CHAR_NINE)))
		else $error("character outside digit and minus set");

	assert property (@(posedge clk) disable iff (!arst_n)
		text.valid && (text.char_code == CHAR_MINUS) |-> !text.last_char)
		else $error("minus sign flagged as last character");

	assert property (@(posedge clk) disable iff (!arst_n)
		text.valid && start_q && (text.char_code == CHAR_ZERO) |-> text.last_char)
		else $error("leading zero in multi-digit text");

endmodule

// ===== tb/sv/tb_signed_binary_to_decimal_ascii_unit.sv =====
// Testbench for signed_binary_to_decimal_ascii_unit: random and directed integers go in,
// each returned character is checked against a local decimal-text predictor.
// Depends on sbda_pkg, sbda_in_if, sbda_out_if and the unit itself.
module tb_signed_binary_to_decimal_ascii_unit;
	import sbda_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_char_t;

	logic clk;
	logic arst_n;

	sbda_in_if  number_if ();
	sbda_out_if text_if ();

	signed_binary_to_decimal_ascii_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.number (number_if),
		.text   (text_if)
	);

	text_char_t expected_text[$];
	int         numbers_sent;
	int         chars_checked;
	int         mismatches;
	int         cycles;
	bit         src_gaps;
	bit         sink_gaps;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters pending", cycles,
				expected_text.size());
			$display("tb: failure");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		mismatches++;
	endtask

	// Expected characters of one number: sign first, then digits most significant first.
	function automatic void predict_text(input logic [VALUE_BITS-1:0] value);
		logic [VALUE_BITS-1:0] mask;
		logic [VALUE_BITS-1:0] raw;
		logic [VALUE_BITS-1:0] mag;
		logic [3:0]            digs[24];
		int                    nd;
		logic                  negative;
		text_char_t            c;
		mask = (VALUE_WIDTH >= VALUE_BITS) ? '1 : (({VALUE_BITS{1'b0}} | 1'b1) << VALUE_WIDTH) - 1;
		raw = value & mask;
		negative = raw[VALUE_WIDTH-1];
		mag = negative ? ((~raw + 1'b1) & mask) : raw;
		nd = 0;
		do begin
			digs[nd] = 4'(mag % 10);
			nd++;
			mag = mag / 10;
		end while (mag != 0);
		if (negative) begin
			c.code = CHAR_MINUS;
			c.last = 1'b0;
			expected_text.push_back(c);
		end
		for (int k = nd - 1; k >= 0; k--) begin
			c.code = CHAR_ZERO + CHAR_W'(digs[k]);
			c.last = (k == 0);
			expected_text.push_back(c);
		end
	endfunction

	// One request on the number channel; called and returns at a rising edge.
	task automatic send_number(input logic [VALUE_BITS-1:0] value);
		int gap;
		gap = src_gaps ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			number_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		number_if.valid <= 1'b1;
		number_if.value <= value;
		do @(posedge clk); while (!number_if.ready);
		predict_text(value);
		numbers_sent++;
	endtask

	// Sink side: with sink_gaps set, a fresh stall for every character.
	initial begin
		int stall;
		text_if.ready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			stall = sink_gaps ? $urandom_range(0, 4) : 0;
			if (stall > 0) begin
				text_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			text_if.ready <= 1'b1;
			do @(posedge clk); while (!text_if.valid);
		end
	end

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && text_if.valid && text_if.ready) begin
			if (expected_text.size() == 0) begin
				report_mismatch($sformatf("unexpected char %h last %b", text_if.char_code,
					text_if.last_char));
			end else begin
				want = expected_text.pop_front();
				if (text_if.char_code !== want.code)
					report_mismatch($sformatf("char %0d: code %h, want %h", chars_checked,
						text_if.char_code, want.code));
				if (text_if.last_char !== want.last)
					report_mismatch($sformatf("char %0d: last_char %b, want %b", chars_checked,
						text_if.last_char, want.last));
			end
			chars_checked++;
		end
	end

	function automatic logic [VALUE_BITS-1:0] pow10(input int n);
		logic [VALUE_BITS-1:0] p;
		p = 1;
		repeat (n) p = p * 10;
		return p;
	endfunction

	// Mix of full-width patterns, chosen digit counts, small values and values near the ends.
	function automatic logic [VALUE_BITS-1:0] rand_value();
		logic [VALUE_BITS-1:0] v;
		logic [VALUE_BITS-1:0] full;
		full = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: v = full;
			1: begin
				v = full % pow10($urandom_range(1, 19));
				if ($urandom_range(0, 1)) v = -v;
			end
			2: v = $signed(64'($urandom_range(0, 200))) - 100;
			default: begin
				v = 64'($urandom_range(0, 15));
				v = $urandom_range(0, 1) ? {1'b1, 63'd0} + v : {1'b0, {63{1'b1}}} - v;
			end
		endcase
		return v;
	endfunction

	task automatic test_directed();
		logic [VALUE_BITS-1:0] vals[$];
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
		vals = '{64'd0, 64'd1, -64'sd1, 64'd9, 64'd10, -64'sd10, 64'd99, -64'sd100,
			64'd1234567890, -64'sd987654321, {1'b0, {63{1'b1}}}, {1'b1, 63'd0},
			{1'b1, 63'd0} + 1, {1'b0, {63{1'b1}}} - 1, 64'd1000000000000000000,
			64'd999999999999999999, -64'sd1000000000000000000, 64'h5555555555555555,
			64'haaaaaaaaaaaaaaaa};
		foreach (vals[i]) send_number(vals[i]);
	endtask

	task automatic test_random(input int count);
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
		repeat (count) send_number(rand_value());
	endtask

	// No idling on either side: no source gaps and no sink stalls.
	task automatic test_back_to_back(input int count);
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		repeat (count) send_number(rand_value());
	endtask

	// Requests offered without gaps while the sink stalls.
	task automatic test_stalled_sink(input int count);
		src_gaps = 1'b0;
		sink_gaps = 1'b1;
		repeat (count) send_number(rand_value());
	endtask

	initial begin
		arst_n = 1'b0;
		number_if.valid = 1'b0;
		number_if.value = '0;
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(160);
		test_back_to_back(40);
		test_stalled_sink(40);
		number_if.valid <= 1'b0;

		while (expected_text.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("converted %0d numbers, checked %0d characters, %0d mismatches",
			numbers_sent, chars_checked, mismatches);
		if (mismatches == 0 && expected_text.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
